/* rtl/matrix_vector_multiply_unit_defines.svh */
// Assertion macros used by the checker of this block.
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MVM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mvm_pkg.sv */
package mvm_pkg;

    localparam int unsigned MAX_ROWS_DEF = 64;
    localparam int unsigned MAX_COLS_DEF = 64;
    localparam int unsigned MAX_VEC_DEF  = 64;

    localparam int unsigned IDX_W     = 6;
    localparam int unsigned STORE_DIM = 1 << IDX_W;
    localparam int unsigned ADDR_W    = 2 * IDX_W;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned SUM_W     = 40;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_WR_MAT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_VEC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_VEC_ZERO  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_VEC_LONG  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_MAT_ZERO  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_MAT_LARGE = 3'd4;
    localparam logic [ERR_W-1:0] ERR_MISMATCH  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LEN = 2'd2;

    // Sideband that travels with each store read through the MAC pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic zero;
    } mvm_tag_t;

endpackage

/* rtl/mvm_store.sv */
module mvm_store (
    input  logic                       clk,
    input  logic                       wr_mat,
    input  logic                       wr_vec,
    input  logic [mvm_pkg::IDX_W-1:0]  wr_row,
    input  logic [mvm_pkg::IDX_W-1:0]  wr_col,
    input  logic [mvm_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [mvm_pkg::IDX_W-1:0]  rd_row,
    input  logic [mvm_pkg::IDX_W-1:0]  rd_col,
    output logic [mvm_pkg::DATA_W-1:0] rd_mat,
    output logic [mvm_pkg::DATA_W-1:0] rd_vec
);
    import mvm_pkg::*;

    logic [DATA_W-1:0] mat_mem [STORE_DIM*STORE_DIM];
    logic [DATA_W-1:0] vec_mem [STORE_DIM];
    logic [DATA_W-1:0] rd_mat_reg;
    logic [DATA_W-1:0] rd_vec_reg;

    always_ff @(posedge clk)
    begin
        if (wr_mat)
        begin
            mat_mem[{wr_row, wr_col}] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mat_reg <= mat_mem[{rd_row, rd_col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_vec)
        begin
            vec_mem[wr_col] <= wr_data;
        end
        if (rd_en)
        begin
            rd_vec_reg <= vec_mem[rd_col];
        end
    end

    assign rd_mat = rd_mat_reg;
    assign rd_vec = rd_vec_reg;

endmodule

/* rtl/mvm_mac.sv */
module mvm_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mvm_pkg::mvm_tag_t                issue_tag,
    input  logic signed [mvm_pkg::DATA_W-1:0] mat_data,
    input  logic signed [mvm_pkg::DATA_W-1:0] vec_data,
    output logic signed [mvm_pkg::SUM_W-1:0]  sum,
    output logic                             sum_done
);
    import mvm_pkg::*;

    mvm_tag_t                   tag_d_reg;
    mvm_tag_t                   tag_p_reg;
    logic                       done_reg;
    logic                       done_next;
    logic signed [PROD_W-1:0]   prod_raw;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SUM_W-1:0]    acc_next;

    assign prod_raw  = mat_data * vec_data;
    // Terms past the store bounds count as zero
    assign prod_next = tag_d_reg.zero ? '0 : prod_raw;
    assign acc_next  = tag_p_reg.first ? SUM_W'(prod_reg) : acc_reg + SUM_W'(prod_reg);
    assign done_next = tag_p_reg.valid && tag_p_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg <= '0;
            tag_p_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_d_reg <= issue_tag;
            tag_p_reg <= tag_d_reg;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_d_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (tag_p_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum      = acc_reg;
    assign sum_done = done_reg;

endmodule

/* rtl/matrix_vector_multiply_unit.sv */
// Element writes stream back to back while the unit is idle.
// A compute walks the matrix store one row at a time, one element per cycle
// while in ST_ISSUE, then drains the MAC pipe and emits the row sum in ST_EMIT;
// a size error gives its result through ST_ERR after acceptance.
// The single read port of the matrix store sets the pace of a compute.
// Reset sets all size registers to 1; the stores hold no reset value.
module matrix_vector_multiply_unit #(
    parameter int unsigned MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_COLS = mvm_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_VEC  = mvm_pkg::MAX_VEC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mvm_pkg::CNT_W-1:0]         cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [mvm_pkg::FUNC_W-1:0]        func,
    input  logic [mvm_pkg::IDX_W-1:0]         row_index,
    input  logic [mvm_pkg::IDX_W-1:0]         col_index,
    input  logic signed [mvm_pkg::DATA_W-1:0] value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [mvm_pkg::IDX_W-1:0]         out_row,
    output logic signed [mvm_pkg::SUM_W-1:0]  row_sum,
    output logic [mvm_pkg::ERR_W-1:0]         error_code,
    output logic                              last
);
    import mvm_pkg::*;

    localparam logic [CNT_W:0] MAX_ROWS_LIM = (CNT_W+1)'(MAX_ROWS);
    localparam logic [CNT_W:0] MAX_COLS_LIM = (CNT_W+1)'(MAX_COLS);
    localparam logic [CNT_W:0] MAX_VEC_LIM  = (CNT_W+1)'(MAX_VEC);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          num_rows_reg, num_rows_next;
    logic [CNT_W-1:0]          num_cols_reg, num_cols_next;
    logic [CNT_W-1:0]          vector_len_reg, vector_len_next;
    logic [CNT_W-1:0]          row_reg, row_next;
    logic [CNT_W-1:0]          col_reg, col_next;
    logic [ERR_W-1:0]          err_reg, err_next;
    logic                      res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]          out_row_reg, out_row_next;
    logic signed [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic [ERR_W-1:0]          error_code_reg, error_code_next;
    logic                      last_reg, last_next;

    logic                      cmd_acc;
    logic                      out_free;
    logic                      col_last;
    logic                      row_last;
    logic [ERR_W-1:0]          chk_err;
    mvm_tag_t                  issue_tag;
    logic [DATA_W-1:0]         rd_mat;
    logic [DATA_W-1:0]         rd_vec;
    logic signed [SUM_W-1:0]   sum;
    logic                      sum_done;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign col_last  = (col_reg == num_cols_reg - CNT_W'(1));
    assign row_last  = (row_reg == num_rows_reg - CNT_W'(1));

    always_comb
    begin
        if (vector_len_reg == '0)
            chk_err = ERR_VEC_ZERO;
        else if ({1'b0, vector_len_reg} > MAX_VEC_LIM)
            chk_err = ERR_VEC_LONG;
        else if (num_rows_reg == '0 || num_cols_reg == '0)
            chk_err = ERR_MAT_ZERO;
        else if ({1'b0, num_rows_reg} > MAX_ROWS_LIM || {1'b0, num_cols_reg} > MAX_COLS_LIM)
            chk_err = ERR_MAT_LARGE;
        else if (num_cols_reg != vector_len_reg)
            chk_err = ERR_MISMATCH;
        else
            chk_err = ERR_OK;
    end

    always_comb
    begin
        issue_tag.valid = (state_reg == ST_ISSUE);
        issue_tag.first = (col_reg == '0);
        issue_tag.last  = col_last;
        // rows or columns beyond the store read as zero
        issue_tag.zero  = (row_reg[CNT_W-1:IDX_W] != '0) || (col_reg[CNT_W-1:IDX_W] != '0);
    end

    mvm_store u_store (
        .clk     (clk),
        .wr_mat  (cmd_acc && func == FUNC_WR_MAT),
        .wr_vec  (cmd_acc && func == FUNC_WR_VEC),
        .wr_row  (row_index),
        .wr_col  (col_index),
        .wr_data (value),
        .rd_en   (issue_tag.valid),
        .rd_row  (row_reg[IDX_W-1:0]),
        .rd_col  (col_reg[IDX_W-1:0]),
        .rd_mat  (rd_mat),
        .rd_vec  (rd_vec)
    );

    mvm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .mat_data  (rd_mat),
        .vec_data  (rd_vec),
        .sum       (sum),
        .sum_done  (sum_done)
    );

    always_comb
    begin
        state_next      = state_reg;
        num_rows_next   = num_rows_reg;
        num_cols_next   = num_cols_reg;
        vector_len_next = vector_len_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        err_next        = err_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        out_row_next    = out_row_reg;
        row_sum_next    = row_sum_reg;
        error_code_next = error_code_reg;
        last_next       = last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_NUM_ROWS:   num_rows_next   = cfg_data;
                REG_NUM_COLS:   num_cols_next   = cfg_data;
                REG_VECTOR_LEN: vector_len_next = cfg_data;
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && func == FUNC_COMPUTE)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    err_next   = chk_err;
                    state_next = (chk_err != ERR_OK) ? ST_ERR : ST_ISSUE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    out_row_next    = '0;
                    row_sum_next    = '0;
                    error_code_next = err_reg;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                col_next = col_reg + CNT_W'(1);
                if (col_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sum_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    out_row_next    = row_reg[IDX_W-1:0];
                    row_sum_next    = sum;
                    error_code_next = ERR_OK;
                    last_next       = row_last;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + CNT_W'(1);
                        col_next   = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_rows_reg   <= CNT_W'(1);
            num_cols_reg   <= CNT_W'(1);
            vector_len_reg <= CNT_W'(1);
            row_reg        <= '0;
            col_reg        <= '0;
            err_reg        <= ERR_OK;
            res_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            row_sum_reg    <= '0;
            error_code_reg <= ERR_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            vector_len_reg <= vector_len_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            err_reg        <= err_next;
            res_valid_reg  <= res_valid_next;
            out_row_reg    <= out_row_next;
            row_sum_reg    <= row_sum_next;
            error_code_reg <= error_code_next;
            last_reg       <= last_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_row    = out_row_reg;
    assign row_sum    = row_sum_reg;
    assign error_code = error_code_reg;
    assign last       = last_reg;

endmodule

/* rtl/mvm_checker.sv */
`include "matrix_vector_multiply_unit_defines.svh"

module mvm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_ready,
    input  logic [mvm_pkg::FUNC_W-1:0]        func,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  logic [mvm_pkg::IDX_W-1:0]         out_row,
    input  logic signed [mvm_pkg::SUM_W-1:0]  row_sum,
    input  logic [mvm_pkg::ERR_W-1:0]         error_code,
    input  logic                              last
);
    import mvm_pkg::*;

    `MVM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(row_sum) && $stable(out_row) && $stable(error_code) && $stable(last), "result changed while stalled")

    `MVM_ASSERT_NOW(a_err_shape, res_valid && error_code != ERR_OK, last && row_sum == '0 && out_row == '0, "error result not a lone zero transaction")

    `MVM_ASSERT_NEXT(a_compute_busy, cmd_valid && cmd_ready && func == FUNC_COMPUTE, !cmd_ready, "compute did not block the command channel")

    `MVM_ASSERT_NEXT(a_write_fast, cmd_valid && cmd_ready && (func == FUNC_WR_MAT || func == FUNC_WR_VEC), cmd_ready, "element write stalled the command channel")

endmodule

bind matrix_vector_multiply_unit mvm_checker u_mvm_checker (.*);

/* bench/matrix_vector_multiply_unit_tb.sv */
`timescale 1ns / 100ps

module matrix_vector_multiply_unit_tb;
    import mvm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int                STALL_PCT   = 14;
    localparam int                SHOW_MAX    = 50;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic [ERR_W-1:0]        err;
        logic                    last;
    } sum_item_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CNT_W-1:0]         cfg_data;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic [FUNC_W-1:0]        func;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value;
    logic                     res_valid;
    logic                     res_ready;
    logic [IDX_W-1:0]         out_row;
    logic signed [SUM_W-1:0]  row_sum;
    logic [ERR_W-1:0]         error_code;
    logic                     last;

    matrix_vector_multiply_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .func       (func),
        .row_index  (row_index),
        .col_index  (col_index),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_row    (out_row),
        .row_sum    (row_sum),
        .error_code (error_code),
        .last       (last)
    );

    // predictor copy of the sizes and stores
    logic [CNT_W-1:0]         cfg_rows = 8'd1;
    logic [CNT_W-1:0]         cfg_cols = 8'd1;
    logic [CNT_W-1:0]         cfg_vlen = 8'd1;
    logic signed [DATA_W-1:0] mat_vals [STORE_DIM][STORE_DIM];
    logic signed [DATA_W-1:0] vec_vals [STORE_DIM];

    // entries already queued for writing, so a compute never reads a blank entry
    bit                       mat_set [STORE_DIM][STORE_DIM];
    bit                       vec_set [STORE_DIM];

    cmd_item_t                cmd_pend[$];
    sum_item_t                sums_due[$];
    int                       n_pushed = 0;
    int                       n_taken  = 0;
    int                       n_noise  = 0;
    int                       n_bad    = 0;
    bit                       calm     = 0;
    logic                     cmd_fire = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [ERR_W-1:0] size_error();
        if (cfg_vlen == 0)
            return ERR_VEC_ZERO;
        if (cfg_vlen > MAX_VEC_DEF)
            return ERR_VEC_LONG;
        if (cfg_rows == 0 || cfg_cols == 0)
            return ERR_MAT_ZERO;
        if (cfg_rows > MAX_ROWS_DEF || cfg_cols > MAX_COLS_DEF)
            return ERR_MAT_LARGE;
        if (cfg_cols != cfg_vlen)
            return ERR_MISMATCH;
        return ERR_OK;
    endfunction

    task automatic predict_cmd(input cmd_item_t it);
        logic [ERR_W-1:0]        code;
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  acc;
        sum_item_t               res;
        case (it.func)
            FUNC_WR_MAT: mat_vals[it.row][it.col] = it.value;
            FUNC_WR_VEC: vec_vals[it.col] = it.value;
            FUNC_COMPUTE:
            begin
                code = size_error();
                if (code != ERR_OK)
                begin
                    res = '{row: '0, sum: '0, err: code, last: 1'b1};
                    sums_due.push_back(res);
                end
                else
                begin
                    for (int i = 0; i < cfg_rows; i++)
                    begin
                        acc = '0;
                        for (int j = 0; j < cfg_cols; j++)
                        begin
                            prod = mat_vals[i][j] * vec_vals[j];
                            acc  = acc + prod;
                        end
                        res = '{row: 6'(i), sum: acc, err: ERR_OK,
                                last: (i == cfg_rows - 1)};
                        sums_due.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // command driver: one item per transaction, held until taken
    always @(negedge clk)
    begin : drive_cmd
        cmd_item_t nxt;
        res_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
        if (rst_n && !(cmd_valid && !cmd_fire))
        begin
            if (cmd_pend.size() > 0 && (calm || $urandom_range(0, 99) >= STALL_PCT))
            begin
                nxt = cmd_pend.pop_front();
                cmd_valid <= 1'b1;
                func      <= nxt.func;
                row_index <= nxt.row;
                col_index <= nxt.col;
                value     <= nxt.value;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each command transaction, checks each result transaction
    always @(posedge clk)
    begin : watch
        cmd_item_t taken;
        sum_item_t want;
        cmd_fire <= cmd_valid && cmd_ready;
        if (rst_n && cmd_valid && cmd_ready)
        begin
            taken = '{func: func, row: row_index, col: col_index, value: value};
            predict_cmd(taken);
            n_taken++;
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (sums_due.size() == 0)
            begin
                n_bad++;
                if (n_bad <= SHOW_MAX)
                    $display("%0t: unexpected result row %0d sum %0d err %0d last %0b",
                             $time, out_row, row_sum, error_code, last);
            end
            else
            begin
                want = sums_due.pop_front();
                if (out_row !== want.row || row_sum !== want.sum ||
                    error_code !== want.err || last !== want.last)
                begin
                    n_bad++;
                    if (n_bad <= SHOW_MAX)
                        $display({"%0t: mismatch expected row %0d sum %0d err %0d last %0b,",
                                  " got row %0d sum %0d err %0d last %0b"},
                                 $time, want.row, $signed(want.sum), want.err, want.last,
                                 out_row, row_sum, error_code, last);
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int area_lim(input logic [CNT_W-1:0] n);
        return (n == 0 || n > STORE_DIM) ? STORE_DIM : int'(n);
    endfunction

    task automatic put_cmd(input logic [FUNC_W-1:0] f, input int r, input int c,
                           input logic [DATA_W-1:0] v);
        cmd_item_t it;
        it = '{func: f, row: 6'(r), col: 6'(c), value: v};
        if (f == FUNC_WR_MAT)
            mat_set[it.row][it.col] = 1'b1;
        if (f == FUNC_WR_VEC)
            vec_set[it.col] = 1'b1;
        cmd_pend.push_back(it);
        n_pushed++;
    endtask

    task automatic put_noise();
        put_cmd(FUNC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
        n_noise++;
    endtask

    // fills whatever the compute will read and is still blank, then starts it
    task automatic put_compute();
        if (size_error() == ERR_OK)
        begin
            for (int i = 0; i < cfg_rows; i++)
                for (int j = 0; j < cfg_cols; j++)
                    if (!mat_set[i][j])
                        put_cmd(FUNC_WR_MAT, i, j, rand_value());
            for (int j = 0; j < cfg_cols; j++)
                if (!vec_set[j])
                    put_cmd(FUNC_WR_VEC, $urandom_range(0, 63), j, rand_value());
        end
        put_cmd(FUNC_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
    endtask

    // the bench issues these writes only when nothing is in flight, so the predictor updates here
    task automatic set_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_NUM_ROWS:   cfg_rows = data;
            REG_NUM_COLS:   cfg_cols = data;
            REG_VECTOR_LEN: cfg_vlen = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] c,
                             input logic [CNT_W-1:0] v);
        set_cfg(REG_NUM_ROWS, r);
        set_cfg(REG_NUM_COLS, c);
        set_cfg(REG_VECTOR_LEN, v);
    endtask

    task automatic drain();
        while (n_taken != n_pushed || sums_due.size() != 0)
            @(posedge clk);
        // trailing writes give no result, allow them to settle
        repeat (10) @(posedge clk);
    endtask

    task automatic try_sizes(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] c,
                             input logic [CNT_W-1:0] v);
        set_sizes(r, c, v);
        put_compute();
        drain();
    endtask

    initial
    begin : stimulus
        int               ph;
        int               len;
        int               pick;
        logic [CNT_W-1:0] nr;
        logic [CNT_W-1:0] nc;
        logic [CNT_W-1:0] nv;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cmd_valid = 1'b0;
        func      = '0;
        row_index = '0;
        col_index = '0;
        value     = '0;
        res_ready = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes are 1 x 1: extreme products
        put_cmd(FUNC_WR_MAT, 0, 0, 16'h8000);
        put_cmd(FUNC_WR_VEC, 0, 0, 16'h8000);
        put_compute();
        put_cmd(FUNC_WR_MAT, 0, 0, 16'h7fff);
        put_compute();
        put_cmd(FUNC_WR_VEC, 0, 0, 16'h7fff);
        put_compute();
        put_noise();
        put_cmd(FUNC_WR_VEC, 0, 0, 16'h0000);
        put_compute();
        drain();

        // size checks, including which one wins when several fail
        try_sizes(8'd1, 8'd1, 8'd0);
        try_sizes(8'd0, 8'd0, 8'd0);
        try_sizes(8'd1, 8'd1, 8'd65);
        try_sizes(8'd0, 8'd1, 8'd255);
        try_sizes(8'd0, 8'd1, 8'd1);
        try_sizes(8'd1, 8'd0, 8'd1);
        try_sizes(8'd65, 8'd0, 8'd1);
        try_sizes(8'd65, 8'd1, 8'd1);
        try_sizes(8'd1, 8'd255, 8'd1);
        try_sizes(8'd255, 8'd2, 8'd1);
        try_sizes(8'd1, 8'd2, 8'd1);
        try_sizes(8'd2, 8'd2, 8'd2);

        // unknown register index must leave the sizes alone
        set_cfg(2'd3, 8'hff);
        put_compute();
        drain();

        // all rows in use, no idling on either side
        calm = 1;
        set_sizes(8'd64, 8'd1, 8'd1);
        put_compute();
        put_cmd(FUNC_WR_MAT, 63, 0, 16'h8000);
        put_cmd(FUNC_WR_VEC, 0, 0, 16'h8000);
        put_cmd(FUNC_WR_MAT, 0, 0, 16'h7fff);
        put_compute();
        drain();
        calm = 0;

        ph = 0;
        while (n_pushed - n_noise < 280)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // mostly broken sizes
                nr = ($urandom_range(0, 2) == 0) ? 8'(64 + $urandom_range(0, 191))
                                                 : 8'($urandom_range(0, 9));
                nc = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
                nv = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
            end
            else if (pick == 1)
            begin
                nr = 8'd64;
                nc = 8'($urandom_range(1, 3));
                nv = nc;
            end
            else if (pick == 2)
            begin
                nr = 8'($urandom_range(1, 2));
                nc = 8'd64;
                nv = nc;
            end
            else
            begin
                nr = 8'($urandom_range(1, 8));
                nc = 8'($urandom_range(1, 8));
                nv = nc;
            end
            calm = (ph % 6 == 3);
            set_sizes(nr, nc, nv);
            if ($urandom_range(0, 7) == 0)
                set_cfg(2'd3, 8'($urandom));

            len = $urandom_range(8, 20);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    put_cmd(FUNC_WR_MAT, $urandom_range(0, area_lim(cfg_rows) - 1),
                            $urandom_range(0, area_lim(cfg_cols) - 1), rand_value());
                else if (pick < 6)
                    put_cmd(FUNC_WR_VEC, $urandom_range(0, 63),
                            $urandom_range(0, area_lim(cfg_cols) - 1), rand_value());
                else if (pick < 9)
                    put_compute();
                else
                    put_noise();
            end
            put_compute();
            drain();
            ph++;
        end
        calm = 0;

        repeat (20) @(posedge clk);
        if (n_bad == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
